[rtl/uxbm_pkg.sv]
// shared types, codes and helpers for the bank mapper decoder
package uxbm_pkg;

  typedef enum logic [1:0] {
    ACT_CPU_RD = 2'd0,
    ACT_CPU_WR = 2'd1,
    ACT_PPU_RD = 2'd2,
    ACT_PPU_WR = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    TGT_NONE      = 4'd0,
    TGT_RAM       = 4'd1,
    TGT_PPU_REGS  = 4'd2,
    TGT_JOYPAD    = 4'd3,
    TGT_APU       = 4'd4,
    TGT_DMA       = 4'd5,
    TGT_BATTERY   = 4'd6,
    TGT_PRG       = 4'd7,
    TGT_BANK_SET  = 4'd8,
    TGT_CHR       = 4'd9,
    TGT_NAMETABLE = 4'd10,
    TGT_PALETTE   = 4'd11
  } target_e;

  typedef enum logic [1:0] {
    CFG_BANK_MASK       = 2'd0,
    CFG_FIXED_BANK      = 2'd1,
    CFG_VERTICAL_MIRROR = 2'd2,
    CFG_CHR_IS_RAM      = 2'd3
  } cfg_index_e;

  // kind of work left for the back end
  typedef enum logic [1:0] {
    OP_PASS     = 2'd0,
    OP_BANK_SET = 2'd1,
    OP_PRG_CUR  = 2'd2
  } op_e;

  localparam int unsigned BANK_W   = 4;
  localparam int unsigned OFFS_W   = 14;
  localparam int unsigned MADDR_W  = 18;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 4;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [3:0]         target;
    logic [MADDR_W-1:0] mem_address;
    logic               write_enable;
    logic [7:0]         data_out;
    logic [BANK_W-1:0]  bank_now;
  } rsp_t;

  typedef struct packed {
    logic [BANK_W-1:0] bank_mask;
    logic [BANK_W-1:0] fixed_bank;
    logic              vertical_mirror;
    logic              chr_is_ram;
  } cfg_t;

  typedef struct packed {
    op_e                op;
    target_e            target;
    logic [MADDR_W-1:0] mem_address;
    logic               write_enable;
    logic [7:0]         data_out;
  } entry_t;

  // bank index reduced modulo the number of rom banks; exact for counts from 2 to 32
  function automatic logic [BANK_W-1:0] bank_mod(input logic [BANK_W-1:0] b,
                                                 input int unsigned count);
    logic [BANK_W:0] r;
    logic [BANK_W:0] c;
    r = {1'b0, b};
    c = (BANK_W+1)'(count);
    for (int i = 0; i < 8; i++) begin
      if (r >= c) begin
        r = r - c;
      end
    end
    return r[BANK_W-1:0];
  endfunction

endpackage

[rtl/uxbm_stream_if.sv]
// valid/ready channel carrying one payload struct
interface uxbm_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/uxbm_front.sv]
// front end: classifies a bus access into region, address and pending work
module uxbm_front #(
  parameter int unsigned PRG_BANK_COUNT = 16
) (
  input  uxbm_pkg::req_t   req_i,
  input  uxbm_pkg::cfg_t   cfg_i,
  output uxbm_pkg::entry_t entry_o
);
  import uxbm_pkg::*;

  logic [15:0] a;
  logic [13:0] v;
  logic        wr;
  logic        page;
  action_e     act;

  assign act  = action_e'(req_i.action);
  assign a    = req_i.address;
  assign v    = a[13:0];
  assign wr   = req_i.action[0];
  assign page = cfg_i.vertical_mirror ? v[10] : v[11];

  always_comb begin
    entry_o.op           = OP_PASS;
    entry_o.target       = TGT_NONE;
    entry_o.mem_address  = '0;
    entry_o.write_enable = 1'b0;
    case (act)
      ACT_CPU_RD, ACT_CPU_WR: begin
        if (a[15:13] == 3'b000) begin
          entry_o.target       = TGT_RAM;
          entry_o.mem_address  = MADDR_W'(a[10:0]);
          entry_o.write_enable = wr;
        end else if (a[15:14] == 2'b00) begin
          entry_o.target       = TGT_PPU_REGS;
          entry_o.mem_address  = MADDR_W'(a[2:0]);
          entry_o.write_enable = wr;
        end else if (a[15:5] == 11'h200) begin
          entry_o.mem_address  = MADDR_W'(a);
          entry_o.write_enable = wr;
          if (wr) begin
            if (a[4:0] == 5'h14) entry_o.target = TGT_DMA;
            else if (a[4:0] == 5'h16) entry_o.target = TGT_JOYPAD;
            else entry_o.target = TGT_APU;
          end else begin
            entry_o.target = (a[4:1] == 4'hB) ? TGT_JOYPAD : TGT_APU;
          end
        end else if (a[15:13] == 3'b010) begin
          entry_o.target = TGT_NONE;
        end else if (a[15:13] == 3'b011) begin
          entry_o.target       = TGT_BATTERY;
          entry_o.mem_address  = MADDR_W'(a[12:0]);
          entry_o.write_enable = wr;
        end else if (wr) begin
          if (cfg_i.bank_mask != '0) begin
            entry_o.op           = OP_BANK_SET;
            entry_o.target       = TGT_BANK_SET;
            entry_o.mem_address  = MADDR_W'(req_i.write_data[BANK_W-1:0] & cfg_i.bank_mask);
            entry_o.write_enable = 1'b1;
          end
        end else if (!a[14]) begin
          entry_o.op          = OP_PRG_CUR;
          entry_o.target      = TGT_PRG;
          entry_o.mem_address = MADDR_W'(a[13:0]);
        end else begin
          entry_o.target      = TGT_PRG;
          entry_o.mem_address = {bank_mod(cfg_i.fixed_bank, PRG_BANK_COUNT), a[13:0]};
        end
      end
      ACT_PPU_RD, ACT_PPU_WR: begin
        if (!v[13]) begin
          if (!wr || cfg_i.chr_is_ram) begin
            entry_o.target       = TGT_CHR;
            entry_o.mem_address  = MADDR_W'(v[12:0]);
            entry_o.write_enable = wr;
          end
        end else if (v[13:8] != 6'h3F) begin
          entry_o.target       = TGT_NAMETABLE;
          entry_o.mem_address  = MADDR_W'({page, v[9:0]});
          entry_o.write_enable = wr;
        end else begin
          entry_o.target       = TGT_PALETTE;
          entry_o.mem_address  = MADDR_W'(v[4:0]);
          entry_o.write_enable = wr;
        end
      end
      default: begin
        entry_o.target = TGT_NONE;
      end
    endcase
    entry_o.data_out = entry_o.write_enable ? req_i.write_data : 8'h00;
  end

endmodule

[rtl/uxbm_fifo.sv]
// two-entry queue between front and back end
module uxbm_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  uxbm_pkg::entry_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output uxbm_pkg::entry_t pop_data_o
);
  import uxbm_pkg::*;

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o     = (cnt_q == CNT_W'(DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/uxbm_back.sv]
// back end: owns the bank register, finishes prg addresses, holds the result
module uxbm_back #(
  parameter int unsigned PRG_BANK_COUNT = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  uxbm_pkg::entry_t entry_i,
  output logic             pop_o,
  uxbm_stream_if.source    rsp_if
);
  import uxbm_pkg::*;

  logic              valid_q;
  rsp_t              rsp_q, rsp_d;
  logic [BANK_W-1:0] bank_q, bank_d;

  assign pop_o = valid_i && (!valid_q || rsp_if.ready);

  always_comb begin
    bank_d            = bank_q;
    rsp_d.target      = entry_i.target;
    rsp_d.mem_address = entry_i.mem_address;
    rsp_d.write_enable = entry_i.write_enable;
    rsp_d.data_out    = entry_i.data_out;
    case (entry_i.op)
      OP_BANK_SET: begin
        bank_d = entry_i.mem_address[BANK_W-1:0];
      end
      OP_PRG_CUR: begin
        rsp_d.mem_address = {bank_mod(bank_q, PRG_BANK_COUNT),
                             entry_i.mem_address[OFFS_W-1:0]};
      end
      default: begin
        bank_d = bank_q;
      end
    endcase
    rsp_d.bank_now = bank_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      bank_q  <= '0;
    end else begin
      if (pop_o) begin
        valid_q <= 1'b1;
        bank_q  <= bank_d;
      end else if (rsp_if.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_if.valid = valid_q;
  assign rsp_if.data  = rsp_q;

endmodule

[rtl/uxrom_bank_mapper_decode.sv]
// top level of the switchable-bank cartridge mapper decoder
//
//   channel  dir  payload                                              handshake
//   req_if   in   action, address, write_data                          valid/ready
//   rsp_if   out  target, mem_address, write_enable, data_out, bank_now valid/ready
//   cfg      in   cfg_index_i, cfg_data_i                              cfg_we_i
//
// one access per cycle sustained while rsp_if is ready; a result passes through the queue register,
// then the output register in the back end
// the two-entry queue lets the request side keep flowing while a result is stalled
// reset clears the bank register to 0 and loads register defaults
module uxrom_bank_mapper_decode #(
  parameter int unsigned PRG_BANK_COUNT = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [uxbm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [uxbm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  uxbm_stream_if.sink                         req_if,
  uxbm_stream_if.source                       rsp_if
);
  import uxbm_pkg::*;

  cfg_t   cfg_q;
  entry_t front_entry;
  entry_t head_entry;
  logic   fifo_full;
  logic   fifo_valid;
  logic   pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bank_mask       <= 4'hF;
      cfg_q.fixed_bank      <= 4'hF;
      cfg_q.vertical_mirror <= 1'b0;
      cfg_q.chr_is_ram      <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_BANK_MASK:       cfg_q.bank_mask       <= cfg_data_i[BANK_W-1:0];
        CFG_FIXED_BANK:      cfg_q.fixed_bank      <= cfg_data_i[BANK_W-1:0];
        CFG_VERTICAL_MIRROR: cfg_q.vertical_mirror <= cfg_data_i[0];
        CFG_CHR_IS_RAM:      cfg_q.chr_is_ram      <= cfg_data_i[0];
        default:             cfg_q                 <= cfg_q;
      endcase
    end
  end

  uxbm_front #(
    .PRG_BANK_COUNT(PRG_BANK_COUNT)
  ) u_front (
    .req_i  (req_if.data),
    .cfg_i  (cfg_q),
    .entry_o(front_entry)
  );

  assign req_if.ready = !fifo_full;

  uxbm_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (req_if.valid),
    .push_data_i(front_entry),
    .full_o     (fifo_full),
    .pop_i      (pop),
    .valid_o    (fifo_valid),
    .pop_data_o (head_entry)
  );

  uxbm_back #(
    .PRG_BANK_COUNT(PRG_BANK_COUNT)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(fifo_valid),
    .entry_i(head_entry),
    .pop_o  (pop),
    .rsp_if (rsp_if)
  );

endmodule
